[rtl/assert_macros.svh]
// Assertion macros shared by the zigzag matrix sorter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on aclk, off while in reset.
`define ZMS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, clocked on aclk, off while in reset.
`define ZMS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/zms_pkg.sv]
// Shared constants, types and helpers of the zigzag matrix sorter.
package zms_pkg;

    localparam int MAX_ROWS  = 8;
    localparam int MAX_COLS  = 8;
    localparam int DEPTH     = MAX_ROWS * MAX_COLS;
    localparam int VALUE_W   = 32;
    localparam int ROW_W     = 3;
    localparam int COL_W     = 3;
    localparam int DIM_W     = 4;
    localparam int COUNT_W   = $clog2(DEPTH + 1);
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = CFG_IDX_W'(1);

    typedef logic signed [VALUE_W-1:0] value_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic insert;
        logic shift;
        logic clear;
    } cell_ctl_t;

    // snake coordinate generator status
    typedef struct packed {
        logic             active;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } snake_t;

    // dimension minus one: zero acts as one, oversized saturates
    function automatic logic [ROW_W-1:0] clamp_m1(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] d;
        begin
            d = v;
            if (v == '0) begin
                d = DIM_W'(1);
            end else if (v > maxv) begin
                d = maxv;
            end
            return ROW_W'(d - DIM_W'(1));
        end
    endfunction

endpackage

[rtl/zms_cell.sv]
// One cell of the insertion-sort chain: holds one value and its valid flag.
module zms_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  zms_pkg::cell_ctl_t ctl,
    input  zms_pkg::value_t   new_value,
    input  zms_pkg::value_t   prev_value,
    input  logic              prev_valid,
    input  logic              prev_lt,
    input  zms_pkg::value_t   next_value,
    input  logic              next_valid,
    output zms_pkg::value_t   value,
    output logic              valid,
    output logic              lt
);

    zms_pkg::value_t value_reg, value_next;
    logic            valid_reg, valid_next;

    // new value belongs at or before this cell
    assign lt = !valid_reg || (new_value < value_reg);

    always_comb begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctl.clear) begin
            valid_next = 1'b0;
        end else if (ctl.insert) begin
            if (lt) begin
                value_next = prev_lt ? prev_value : new_value;
                valid_next = prev_valid;
            end
        end else if (ctl.shift) begin
            value_next = next_value;
            valid_next = next_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

[rtl/zms_snake.sv]
// Snake-order destination counter used while the sorted chain drains.
module zms_snake (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic                      advance,
    input  logic [zms_pkg::ROW_W-1:0] rows_m1,
    input  logic [zms_pkg::COL_W-1:0] cols_m1,
    output zms_pkg::snake_t           status
);

    localparam logic [zms_pkg::ROW_W-1:0] ROW_ONE = zms_pkg::ROW_W'(1);
    localparam logic [zms_pkg::COL_W-1:0] COL_ONE = zms_pkg::COL_W'(1);

    logic                      active_reg, active_next;
    logic [zms_pkg::ROW_W-1:0] row_reg, row_next;
    logic [zms_pkg::COL_W-1:0] idx_reg, idx_next;
    logic                      row_done;
    logic                      last;

    assign row_done = (idx_reg == cols_m1);
    assign last     = row_done && (row_reg == rows_m1);

    always_comb begin
        active_next = active_reg;
        row_next    = row_reg;
        idx_next    = idx_reg;
        if (start) begin
            active_next = 1'b1;
            row_next    = '0;
            idx_next    = '0;
        end else if (advance) begin
            if (last) begin
                active_next = 1'b0;
            end else if (row_done) begin
                idx_next = '0;
                row_next = row_reg + ROW_ONE;
            end else begin
                idx_next = idx_reg + COL_ONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            row_reg    <= '0;
            idx_reg    <= '0;
        end else begin
            active_reg <= active_next;
            row_reg    <= row_next;
            idx_reg    <= idx_next;
        end
    end

    // odd rows run right to left
    assign status.active = active_reg;
    assign status.row    = row_reg;
    assign status.col    = row_reg[0] ? (cols_m1 - idx_reg) : idx_reg;
    assign status.last   = last;

endmodule

[rtl/zigzag_matrix_sorter.sv]
// Top level of the zigzag matrix sorter: cell chain, loader, drain and output stage.
//
//  port group   dir  handshake          payload
//  s_*          in   s_valid/s_ready    s_element_value
//  m_*          out  m_valid/m_ready    m_dest_row, m_dest_col, m_sorted_value, m_run_end
//  cfg_*        in   cfg_we             cfg_index, cfg_data
//
// Load: one item per cycle while not draining; each value is inserted into the sorted cell chain
// as it arrives, so no sort pass is left when the last element lands.
// Drain: the chain shifts toward cell 0, one result per cycle into the output
// register when the output register is empty or m_ready is high.
// s_ready is low for the whole drain. m_ready low simply holds the chain.
// Reset (aresetn low, synchronous) empties the chain and sets 8 x 8.
// A config write empties the chain and drops any partial matrix.
`include "assert_macros.svh"

module zigzag_matrix_sorter (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input items
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [31:0]            s_element_value,
    // result items
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_dest_row,
    output logic [2:0]                    m_dest_col,
    output logic signed [31:0]            m_sorted_value,
    output logic                          m_run_end,
    // configuration writes
    input  logic                          cfg_we,
    input  logic [zms_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [zms_pkg::DIM_W-1:0]     cfg_data
);

    localparam int DEPTH = zms_pkg::DEPTH;

    // ---------------- configuration ----------------
    logic [zms_pkg::ROW_W-1:0] rows_m1_reg, rows_m1_next;
    logic [zms_pkg::COL_W-1:0] cols_m1_reg, cols_m1_next;
    logic                      cfg_hit;

    always_comb begin
        rows_m1_next = rows_m1_reg;
        cols_m1_next = cols_m1_reg;
        cfg_hit      = 1'b0;
        if (cfg_we) begin
            unique case (cfg_index)
                zms_pkg::REG_ROW_COUNT: begin
                    rows_m1_next = zms_pkg::clamp_m1(cfg_data,
                                                     zms_pkg::DIM_W'(zms_pkg::MAX_ROWS));
                    cfg_hit      = 1'b1;
                end
                zms_pkg::REG_COL_COUNT: begin
                    cols_m1_next = zms_pkg::clamp_m1(cfg_data,
                                                     zms_pkg::DIM_W'(zms_pkg::MAX_COLS));
                    cfg_hit      = 1'b1;
                end
                default: begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    // ---------------- load control ----------------
    logic [zms_pkg::COUNT_W-1:0] loaded_count_reg, loaded_count_next;
    logic [2*zms_pkg::DIM_W-1:0] total;
    logic [zms_pkg::COUNT_W-1:0] total_m1;
    logic                        in_accept;
    logic                        last_in;
    zms_pkg::snake_t             snk;
    logic                        advance;

    assign total = (2*zms_pkg::DIM_W)'({1'b0, rows_m1_reg} + 4'd1)
                 * (2*zms_pkg::DIM_W)'({1'b0, cols_m1_reg} + 4'd1);
    assign total_m1 = zms_pkg::COUNT_W'(total - 8'd1);

    assign s_ready   = !snk.active;
    assign in_accept = s_valid && s_ready;
    assign last_in   = (loaded_count_reg == total_m1);

    always_comb begin
        loaded_count_next = loaded_count_reg;
        if (cfg_hit) begin
            loaded_count_next = '0;
        end else if (in_accept) begin
            loaded_count_next = last_in ? '0 : loaded_count_reg + zms_pkg::COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_m1_reg      <= zms_pkg::ROW_W'(zms_pkg::MAX_ROWS - 1);
            cols_m1_reg      <= zms_pkg::COL_W'(zms_pkg::MAX_COLS - 1);
            loaded_count_reg <= '0;
        end else begin
            rows_m1_reg      <= rows_m1_next;
            cols_m1_reg      <= cols_m1_next;
            loaded_count_reg <= loaded_count_next;
        end
    end

    // ---------------- cell chain ----------------
    // Cell 0 holds the smallest value; empty cells sit at the far end.
    zms_pkg::cell_ctl_t ctl;
    zms_pkg::value_t    cell_value [DEPTH];
    logic [DEPTH-1:0]   cell_valid;
    logic [DEPTH-1:0]   cell_lt;

    assign ctl.clear  = cfg_hit;
    assign ctl.insert = in_accept;
    assign ctl.shift  = advance;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        zms_pkg::value_t p_value, n_value;
        logic            p_valid, p_lt, n_valid;

        if (i == 0) begin : g_head
            // nothing ahead of the head: a value that beats it lands here
            assign p_value = s_element_value;
            assign p_valid = 1'b1;
            assign p_lt    = 1'b0;
        end else begin : g_body
            assign p_value = cell_value[i-1];
            assign p_valid = cell_valid[i-1];
            assign p_lt    = cell_lt[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign n_value = cell_value[i];
            assign n_valid = 1'b0;
        end else begin : g_inner
            assign n_value = cell_value[i+1];
            assign n_valid = cell_valid[i+1];
        end

        zms_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl),
            .new_value  (s_element_value),
            .prev_value (p_value),
            .prev_valid (p_valid),
            .prev_lt    (p_lt),
            .next_value (n_value),
            .next_valid (n_valid),
            .value      (cell_value[i]),
            .valid      (cell_valid[i]),
            .lt         (cell_lt[i])
        );
    end

    // ---------------- drain ----------------
    zms_snake u_snake (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (in_accept && last_in),
        .advance (advance),
        .rows_m1 (rows_m1_reg),
        .cols_m1 (cols_m1_reg),
        .status  (snk)
    );

    // output register decouples the chain from m_ready
    logic                      m_valid_reg, m_valid_next;
    logic [zms_pkg::ROW_W-1:0] m_row_reg;
    logic [zms_pkg::COL_W-1:0] m_col_reg;
    zms_pkg::value_t           m_value_reg;
    logic                      m_end_reg;

    assign advance = snk.active && (!m_valid_reg || m_ready);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_row_reg   <= snk.row;
            m_col_reg   <= snk.col;
            m_value_reg <= cell_value[0];
            m_end_reg   <= snk.last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_dest_row     = m_row_reg;
    assign m_dest_col     = m_col_reg;
    assign m_sorted_value = m_value_reg;
    assign m_run_end      = m_end_reg;

    // ---------------- checks ----------------
    `ZMS_ASSERT_IMPL(a_drain_reads_full, advance, cell_valid[0])
    `ZMS_ASSERT_NEXT(a_chain_empty_after_run, advance && snk.last, cell_valid == '0)
    `ZMS_ASSERT_NEXT(a_run_end_closes, advance && snk.last,
                     m_valid && m_run_end && !snk.active)

endmodule
